// ===== sv/sawsf_pkg.sv =====
// ----------------------------------------------------------------------------
// sawsf_pkg
// shared types and codes for the stop-and-wait stuffed framer
// ----------------------------------------------------------------------------
package sawsf_pkg;

    // input word selector codes (tuser on the slave side)
    localparam logic [1:0] FUNC_DATA = 2'd0;
    localparam logic [1:0] FUNC_ACK  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_MARKER  = 3'd0;
    localparam logic [2:0] REG_START   = 3'd1;
    localparam logic [2:0] REG_END     = 3'd2;
    localparam logic [2:0] REG_PKT_LEN = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    // register reset values
    localparam logic [7:0]  MARKER_RST  = 8'h24;
    localparam logic [7:0]  START_RST   = 8'h2A;
    localparam logic [7:0]  END_RST     = 8'h40;
    localparam logic [3:0]  PKT_LEN_RST = 4'd8;
    localparam logic [15:0] TIMEOUT_RST = 16'd10000;

    // ascii '0', sequence character base
    localparam logic [7:0] SEQ_CHAR_BASE = 8'h30;
    // position of the sequence character in an ack frame
    localparam int unsigned ACK_NUMBER_POS = 2;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_ACKED   = 2'd1,
        KIND_REFUSED = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MARK0,
        F_START,
        F_SEQ,
        F_DATA,
        F_STUFF,
        F_MARK1,
        F_END
    } t_fstate;

    // request from the control logic to the framer / output stage
    typedef struct packed {
        logic  start_frame;
        logic  load_single;
        t_kind kind;
        logic  seq_now;
    } t_req;

    // status from the framer / output stage
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/stop_and_wait_stuffed_framer_core.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_stuffed_framer_core
// stop-and-wait sender: packet store, stuffed framing, ack and timeout handling
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata in_byte, tuser func,
//                                                tlast final_byte
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata out_byte + seq_now,
//                                                tuser result_kind, tlast run_last
// apb       in   psel & penable (pready high)    five config registers in 32-bit words
//
// a word that sends a frame holds s_axis_tready low while the framer emits
//   its bytes (5 + data bytes + doubled marker bytes), one byte a cycle into
//   the output register while m_axis does not stall
// store bytes are read one ahead, so the registered read does not slow the framer
// reset is synchronous, active low; the store has no clearing pass
// a stall on m_axis holds the framer and, once the output register is full,
//   s_axis_tready
//
module stop_and_wait_stuffed_framer_core #(
    parameter int unsigned MAX_PACKET    = 8,
    parameter int unsigned ACK_FRAME_LEN = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    input  logic        s_axis_tlast,   // final_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] seq_now, [15:9] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast,   // run_last

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // fill count holds 0..MAX_PACKET, store address 0..MAX_PACKET-1
    localparam int unsigned CW = $clog2(MAX_PACKET + 1);
    localparam int unsigned AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
    localparam int unsigned LW = (CW > 4) ? CW : 4;
    localparam int unsigned IW = $clog2(ACK_FRAME_LEN + 1);

    // configuration registers
    logic [7:0]  r_marker;
    logic [7:0]  r_start;
    logic [7:0]  r_end;
    logic [3:0]  r_pkt_len;
    logic [15:0] r_timeout;

    // sender state
    logic [CW-1:0] r_fill,    n_fill;
    logic          r_seq,     n_seq;
    logic          r_await,   n_await;
    logic [IW-1:0] r_ack_idx, n_ack_idx;
    logic [7:0]    r_ack_num, n_ack_num;
    logic [15:0]   r_wait,    n_wait;

    sawsf_pkg::t_req  w_req;
    sawsf_pkg::t_stat w_stat;

    logic          w_accept;
    logic          w_cfg_wr;
    logic [2:0]    w_reg_idx;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    logic [LW-1:0] w_limit;
    logic [CW-1:0] w_fill_inc;
    logic [IW-1:0] w_idx_inc;
    logic [7:0]    w_ack_new;
    logic [15:0]   w_wait_inc;
    logic [15:0]   w_tmo;
    logic [7:0]    w_seq_char;
    logic [7:0]    w_out_byte;
    logic          w_out_seq;
    logic [1:0]    w_out_kind;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker  <= sawsf_pkg::MARKER_RST;
            r_start   <= sawsf_pkg::START_RST;
            r_end     <= sawsf_pkg::END_RST;
            r_pkt_len <= sawsf_pkg::PKT_LEN_RST;
            r_timeout <= sawsf_pkg::TIMEOUT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                sawsf_pkg::REG_MARKER:  r_marker  <= pwdata[7:0];
                sawsf_pkg::REG_START:   r_start   <= pwdata[7:0];
                sawsf_pkg::REG_END:     r_end     <= pwdata[7:0];
                sawsf_pkg::REG_PKT_LEN: r_pkt_len <= pwdata[3:0];
                sawsf_pkg::REG_TIMEOUT: r_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            sawsf_pkg::REG_MARKER:  prdata = {24'd0, r_marker};
            sawsf_pkg::REG_START:   prdata = {24'd0, r_start};
            sawsf_pkg::REG_END:     prdata = {24'd0, r_end};
            sawsf_pkg::REG_PKT_LEN: prdata = {28'd0, r_pkt_len};
            sawsf_pkg::REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input word handling
    // ------------------------------------------------------------------
    // one word at a time: no frame in flight and room in the output register
    assign s_axis_tready = !w_stat.busy && w_stat.out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // packet length clamped to 1..MAX_PACKET
    always_comb begin
        if (r_pkt_len == '0) begin
            w_limit = LW'(1);
        end else if (LW'(r_pkt_len) > LW'(MAX_PACKET)) begin
            w_limit = LW'(MAX_PACKET);
        end else begin
            w_limit = LW'(r_pkt_len);
        end
    end

    assign w_tmo      = (r_timeout == '0) ? 16'd1 : r_timeout;
    assign w_fill_inc = r_fill + {{(CW-1){1'b0}}, 1'b1};
    assign w_idx_inc  = r_ack_idx + {{(IW-1){1'b0}}, 1'b1};
    assign w_wait_inc = r_wait + 16'd1;
    assign w_seq_char = sawsf_pkg::SEQ_CHAR_BASE | {7'd0, r_seq};
    assign w_ack_new  = (r_ack_idx == IW'(sawsf_pkg::ACK_NUMBER_POS)) ? s_axis_tdata
                                                                       : r_ack_num;

    // store write only for a data byte taken while idle and not full
    assign w_wr_en = w_accept && (s_axis_tuser == sawsf_pkg::FUNC_DATA) && !r_await
                     && (r_fill < CW'(MAX_PACKET));

    always_comb begin
        n_fill    = r_fill;
        n_seq     = r_seq;
        n_await   = r_await;
        n_ack_idx = r_ack_idx;
        n_ack_num = r_ack_num;
        n_wait    = r_wait;
        w_req     = '{start_frame: 1'b0, load_single: 1'b0,
                      kind: sawsf_pkg::KIND_FRAME, seq_now: r_seq};
        if (w_accept) begin
            unique case (s_axis_tuser)
                sawsf_pkg::FUNC_DATA: begin
                    if (r_await) begin
                        // refused while waiting for an ack
                        w_req.load_single = 1'b1;
                        w_req.kind        = sawsf_pkg::KIND_REFUSED;
                    end else begin
                        if (r_fill < CW'(MAX_PACKET)) n_fill = w_fill_inc;
                        if ((LW'(n_fill) >= w_limit) || s_axis_tlast) begin
                            w_req.start_frame = 1'b1;
                            n_await           = 1'b1;
                            n_ack_idx         = '0;
                            n_wait            = '0;
                        end
                    end
                end
                sawsf_pkg::FUNC_ACK: begin
                    if (r_await) begin
                        n_ack_num = w_ack_new;
                        n_ack_idx = w_idx_inc;
                        if (w_idx_inc >= IW'(ACK_FRAME_LEN)) begin
                            n_ack_idx = '0;
                            if (w_ack_new == w_seq_char) begin
                                // acknowledged: flip sequence, empty store
                                n_seq             = !r_seq;
                                n_await           = 1'b0;
                                n_fill            = '0;
                                n_wait            = '0;
                                w_req.load_single = 1'b1;
                                w_req.kind        = sawsf_pkg::KIND_ACKED;
                                w_req.seq_now     = !r_seq;
                            end else begin
                                // wrong sequence character: resend
                                w_req.start_frame = 1'b1;
                                n_wait            = '0;
                            end
                        end
                    end
                end
                sawsf_pkg::FUNC_TICK: begin
                    if (r_await) begin
                        if (w_wait_inc >= w_tmo) begin
                            w_req.start_frame = 1'b1;
                            n_wait            = '0;
                            n_ack_idx         = '0;
                        end else begin
                            n_wait = w_wait_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_seq     <= 1'b0;
            r_await   <= 1'b0;
            r_ack_idx <= '0;
            r_ack_num <= '0;
            r_wait    <= '0;
        end else begin
            r_fill    <= n_fill;
            r_seq     <= n_seq;
            r_await   <= n_await;
            r_ack_idx <= n_ack_idx;
            r_ack_num <= n_ack_num;
            r_wait    <= n_wait;
        end
    end

    // ------------------------------------------------------------------
    // packet store and framer
    // ------------------------------------------------------------------
    // a byte written at the accept edge is read no earlier than the seq state
    // (marker and start go first), so no forwarding is needed
    sawsf_store #(
        .DEPTH (MAX_PACKET),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sawsf_framer #(
        .CW         (CW),
        .AW         (AW)
    ) u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_stat    (w_stat),
        .i_marker  (r_marker),
        .i_start   (r_start),
        .i_end     (r_end),
        .i_seq     (r_seq),
        .i_count   (r_fill),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (w_out_kind),
        .o_byte    (w_out_byte),
        .o_last    (m_axis_tlast),
        .o_seq     (w_out_seq)
    );

    assign m_axis_tuser = w_out_kind;
    assign m_axis_tdata = {7'd0, w_out_seq, w_out_byte};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a frame start always leaves the sender waiting for an ack
    a_start_awaits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start_frame |=> r_await)
        else $error("frame sent without waiting for ack");

    // the sequence bit only moves together with an acknowledged result
    a_seq_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != $past(r_seq)) |-> $past(w_req.load_single))
        else $error("sequence bit changed without ack");

    // the store is never written while a frame waits for its ack
    a_no_write_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> !w_wr_en)
        else $error("store written while awaiting ack");

    // fill count never runs past the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_PACKET))
        else $error("fill count beyond store depth");

endmodule

// ===== sv/sawsf_store.sv =====
// ----------------------------------------------------------------------------
// sawsf_store
// packet byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module sawsf_store #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sawsf_framer.sv =====
// ----------------------------------------------------------------------------
// sawsf_framer
// frame sequencer and output word register
// ----------------------------------------------------------------------------
module sawsf_framer #(
    parameter int unsigned CW         = 4,
    parameter int unsigned AW         = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sawsf_pkg::t_req   i_req,
    output sawsf_pkg::t_stat  o_stat,
    input  logic [7:0]        i_marker,
    input  logic [7:0]        i_start,
    input  logic [7:0]        i_end,
    input  logic              i_seq,
    input  logic [CW-1:0]     i_count,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic              o_seq
);

    sawsf_pkg::t_fstate r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;

    logic               r_out_valid;
    sawsf_pkg::t_kind   r_out_kind;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_seq;

    logic               w_free;
    logic               w_emit;
    logic [7:0]         w_byte;
    logic               w_last;
    logic [CW-1:0]      w_rd_idx;
    logic [CW:0]        w_idx_inc;
    logic               w_last_idx;
    logic               w_is_marker;

    assign w_free      = !r_out_valid || i_ready;
    assign w_idx_inc   = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};
    assign w_last_idx  = w_idx_inc >= {1'b0, i_count};
    assign w_is_marker = i_rd_data == i_marker;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sawsf_pkg::F_IDLE: begin
                if (i_req.start_frame) n_state = sawsf_pkg::F_MARK0;
            end
            sawsf_pkg::F_MARK0: begin
                if (w_free) n_state = sawsf_pkg::F_START;
            end
            sawsf_pkg::F_START: begin
                if (w_free) n_state = sawsf_pkg::F_SEQ;
            end
            sawsf_pkg::F_SEQ: begin
                if (w_free) begin
                    n_state = (i_count != '0) ? sawsf_pkg::F_DATA : sawsf_pkg::F_MARK1;
                end
            end
            sawsf_pkg::F_DATA: begin
                if (w_free) begin
                    if (w_is_marker)     n_state = sawsf_pkg::F_STUFF;
                    else if (w_last_idx) n_state = sawsf_pkg::F_MARK1;
                end
            end
            sawsf_pkg::F_STUFF: begin
                if (w_free) begin
                    n_state = w_last_idx ? sawsf_pkg::F_MARK1 : sawsf_pkg::F_DATA;
                end
            end
            sawsf_pkg::F_MARK1: begin
                if (w_free) n_state = sawsf_pkg::F_END;
            end
            sawsf_pkg::F_END: begin
                if (w_free) n_state = sawsf_pkg::F_IDLE;
            end
            default: n_state = sawsf_pkg::F_IDLE;
        endcase
    end

    // outputs: emitted word, store read one byte ahead
    always_comb begin
        w_emit   = w_free && (r_state != sawsf_pkg::F_IDLE);
        w_byte   = '0;
        w_last   = 1'b0;
        o_rd_en  = 1'b0;
        w_rd_idx = r_idx;
        n_idx    = r_idx;
        unique case (r_state)
            sawsf_pkg::F_IDLE:  w_byte = '0;
            sawsf_pkg::F_MARK0: w_byte = i_marker;
            sawsf_pkg::F_START: w_byte = i_start;
            sawsf_pkg::F_SEQ: begin
                w_byte = sawsf_pkg::SEQ_CHAR_BASE | {7'd0, i_seq};
                if (w_free) begin
                    n_idx    = '0;
                    w_rd_idx = '0;
                    o_rd_en  = i_count != '0;
                end
            end
            sawsf_pkg::F_DATA: begin
                w_byte = i_rd_data;
                if (w_free && !w_is_marker) begin
                    n_idx    = w_idx_inc[CW-1:0];
                    w_rd_idx = w_idx_inc[CW-1:0];
                    o_rd_en  = !w_last_idx;
                end
            end
            sawsf_pkg::F_STUFF: begin
                w_byte = i_marker;
                if (w_free) begin
                    n_idx    = w_idx_inc[CW-1:0];
                    w_rd_idx = w_idx_inc[CW-1:0];
                    o_rd_en  = !w_last_idx;
                end
            end
            sawsf_pkg::F_MARK1: w_byte = i_marker;
            sawsf_pkg::F_END: begin
                w_byte = i_end;
                w_last = 1'b1;
            end
            default: w_byte = '0;
        endcase
    end

    assign o_rd_addr = w_rd_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sawsf_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit || i_req.load_single) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind <= sawsf_pkg::KIND_FRAME;
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_seq  <= i_seq;
        end else if (i_req.load_single) begin
            r_out_kind <= i_req.kind;
            r_out_byte <= '0;
            r_out_last <= 1'b1;
            r_out_seq  <= i_req.seq_now;
        end
    end

    assign o_stat.busy     = r_state != sawsf_pkg::F_IDLE;
    assign o_stat.out_free = w_free;

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_seq   = r_out_seq;

endmodule
